// ===== src/double_float_remainder_defines.svh =====
// Assertion macros shared by the remainder block.
// No dependencies; included by the top level only.
`ifndef DOUBLE_FLOAT_REMAINDER_DEFINES_SVH
`define DOUBLE_FLOAT_REMAINDER_DEFINES_SVH
// Assert that a condition implies something in the same cycle.
`define DFR_ASSERT_IMP(lbl, clk, rst_n, a, b) \
lbl: assert property (@(posedge clk) disable iff (!rst_n) (a) |-> (b)) \
	else $error("assertion failed");
// Assert that a condition implies something in the next cycle.
`define DFR_ASSERT_NEXT(lbl, clk, rst_n, a, b) \
lbl: assert property (@(posedge clk) disable iff (!rst_n) (a) |=> (b)) \
	else $error("assertion failed");
`endif

// ===== src/dfr_pkg.sv =====
// Package for the binary64 remainder block: constants and helpers.
// No dependencies.
package dfr_pkg;
	localparam int unsigned ExpW = 11;
	localparam int unsigned FracW = 52;
	localparam int unsigned ManW = 53;
	localparam int unsigned WordW = 64;
	// Signed exponent wide enough for subnormal shifts.
	localparam int unsigned EW = 13;
	localparam logic [ExpW-1:0] ExpAllOnes = 11'h7ff;
	localparam logic [WordW-1:0] DefaultQnan = 64'h7FF8000000000000;
	localparam logic [WordW-1:0] QuietBit = 64'h0008000000000000;

	// True when the pattern is a NaN.
	function automatic logic is_nan(input logic [WordW-1:0] v);
		return (v[62:52] == ExpAllOnes) && (v[51:0] != '0);
	endfunction
endpackage

// ===== src/dfr_stream_if.sv =====
// Valid/ready channel carrying a W-bit payload per beat.
// Depends on nothing.
interface dfr_stream_if #(parameter int unsigned W = 64);
	logic valid;
	logic ready;
	logic [W-1:0] data;
	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

// ===== src/double_float_remainder.sv =====
// Top level of the binary64 truncated remainder unit.
// Depends on dfr_pkg, dfr_stream_if and double_float_remainder_defines.svh.
//
//  channel | dir | payload
//  in_ch   | in  | data[127:64] dividend_bits, data[63:0] divisor_bits
//  out_ch  | out | data[63:0] remainder_bits
//
// An operand pair is loaded, then each operand in turn is normalized by
// shifting (up to 52 shifts each), then one shift-subtract step per bit of
// exponent difference (up to 2097) runs in the shared 54-bit subtractor, then
// a final subtract, renormalizing shifts (up to 52), packing and output follow.
// Special cases go from load straight to output.
// The input is not ready while an item is in work; the result waits in an
// output register until taken. Reset clears the sequencer only.
`include "double_float_remainder_defines.svh"
module double_float_remainder
	import dfr_pkg::*;
(
	input logic clk,
	input logic arst_n,
	dfr_stream_if.sink in_ch,
	dfr_stream_if.source out_ch
);
	typedef enum logic [2:0] {
		S_IDLE, S_NORMX, S_NORMY, S_REDUCE, S_LAST, S_RENORM, S_PACK, S_OUT
	} state_t;

	state_t state_q;
	logic [WordW-1:0] res_q;
	logic sx_q;
	logic [ManW:0] mx_q, my_q;
	logic signed [EW-1:0] ex_q, ey_q;

	logic [WordW-1:0] xin, yin;
	logic [ManW:0] diff;
	logic signed [EW-1:0] sh;

	assign xin = in_ch.data[127:64];
	assign yin = in_ch.data[63:0];
	// The one shared subtractor.
	assign diff = mx_q - my_q;
	assign sh = 13'sd1 - ex_q;
	assign in_ch.ready = (state_q == S_IDLE);
	assign out_ch.valid = (state_q == S_OUT);
	assign out_ch.data = res_q;

	// Sequencer with its datapath registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			unique case (state_q)
				S_IDLE: begin
					if (in_ch.valid) begin
						sx_q <= xin[63];
						// A subnormal operand starts at exponent one.
						ex_q <= (xin[62:52] == '0) ? 13'sd1 : EW'(xin[62:52]);
						ey_q <= (yin[62:52] == '0) ? 13'sd1 : EW'(yin[62:52]);
						mx_q <= {1'b0, (xin[62:52] != '0), xin[51:0]};
						my_q <= {1'b0, (yin[62:52] != '0), yin[51:0]};
						if (yin[62:0] == '0 || is_nan(yin) ||
							xin[62:52] == ExpAllOnes) begin
							if (is_nan(xin)) res_q <= xin | QuietBit;
							else if (is_nan(yin)) res_q <= yin | QuietBit;
							else res_q <= DefaultQnan;
							state_q <= S_OUT;
						end else if (xin[62:0] == yin[62:0]) begin
							res_q <= {xin[63], 63'd0};
							state_q <= S_OUT;
						end else if (xin[62:0] < yin[62:0]) begin
							res_q <= xin;
							state_q <= S_OUT;
						end else begin
							state_q <= S_NORMX;
						end
					end
				end
				// Subnormals: shift until the hidden bit appears.
				S_NORMX: begin
					if (!mx_q[FracW]) begin
						mx_q <= mx_q << 1;
						ex_q <= ex_q - 13'sd1;
					end else state_q <= S_NORMY;
				end
				S_NORMY: begin
					if (!my_q[FracW]) begin
						my_q <= my_q << 1;
						ey_q <= ey_q - 13'sd1;
					end else state_q <= (ex_q > ey_q) ? S_REDUCE : S_LAST;
				end
				// One shift-subtract step per exponent bit.
				S_REDUCE: begin
					if (!diff[ManW] && diff == '0) begin
						res_q <= {sx_q, 63'd0};
						state_q <= S_OUT;
					end else begin
						mx_q <= (diff[ManW] ? mx_q : diff) << 1;
						ex_q <= ex_q - 13'sd1;
						if (ex_q - 13'sd1 == ey_q) state_q <= S_LAST;
					end
				end
				S_LAST: begin
					if (!diff[ManW] && diff == '0) begin
						res_q <= {sx_q, 63'd0};
						state_q <= S_OUT;
					end else begin
						if (!diff[ManW]) mx_q <= diff;
						state_q <= S_RENORM;
					end
				end
				S_RENORM: begin
					if (!mx_q[FracW]) begin
						mx_q <= mx_q << 1;
						ex_q <= ex_q - 13'sd1;
					end else state_q <= S_PACK;
				end
				S_PACK: begin
					if (ex_q > 13'sd0) res_q <= {sx_q, ex_q[ExpW-1:0], mx_q[FracW-1:0]};
					else if (sh >= 13'sd64) res_q <= {sx_q, 63'd0};
					else res_q <= {sx_q, 63'(mx_q[ManW-1:0] >> sh[5:0])};
					state_q <= S_OUT;
				end
				S_OUT: begin
					if (out_ch.ready) state_q <= S_IDLE;
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	`DFR_ASSERT_IMP(a_no_overlap, clk, arst_n, out_ch.valid, !in_ch.ready)
	`DFR_ASSERT_NEXT(a_done_idle, clk, arst_n, out_ch.valid && out_ch.ready, in_ch.ready)
	`DFR_ASSERT_IMP(a_reduce_order, clk, arst_n, state_q == S_REDUCE, ex_q > ey_q)
endmodule
